// ===== hdl/axis_angle_rotation_assert.svh =====
// axis_angle_rotation_assert.svh: assertion macros for the axis-angle rotation block.
// Used by hdl/axis_angle_rotation.sv. Define NO_ASSERTIONS to compile them out.
`ifndef AXIS_ANGLE_ROTATION_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AXR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axr: check failed");
// next-cycle implication
`define AXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axr: check failed");
`else
`define AXR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define AXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/axr_pkg.sv =====
// axr_pkg: item types, fixed-point constants and stage map of the axis-angle rotation pipe.
// No dependencies; imported by hdl/axis_angle_rotation.sv, tb/sv/axr_checker.sv and tb/sv/tb_axis_angle_rotation.sv.
`default_nettype none

package axr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // axis length threshold divisor (1e-6 squared, inverted)
    localparam logic [64:0] LEN_DIV = 65'd1000000000000;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic [63:0]        HALF_Q30 = 64'd536870912;

    // odd sine polynomial, Q2.30 magnitudes, alternating signs
    localparam logic [30:0] PC1  = 31'd1686629713;
    localparam logic [30:0] PC3  = 31'd693598668;
    localparam logic [30:0] PC5  = 31'd85569306;
    localparam logic [30:0] PC7  = 31'd5026996;
    localparam logic [30:0] PC9  = 31'd172272;
    localparam logic [30:0] PC11 = 31'd3864;

    // stage map, stage k is written from stage k-1
    localparam int ST_ABS    = 1;
    localparam int ST_SQR    = 2;
    localparam int ST_SUM    = 3;
    localparam int ST_SHIFT  = 4;
    localparam int ST_SQSC   = 5;
    localparam int ST_SSC    = 6;
    localparam int SQ_FIRST  = 7;
    localparam int SQ_LAST   = 38;
    localparam int ST_NUM    = 39;
    localparam int DV_FIRST  = 40;
    localparam int DV_LAST   = 70;
    localparam int ST_SIGN   = 71;
    localparam int ST_TU     = 72;
    localparam int ST_TUU    = 73;
    localparam int ST_MAT    = 74;
    localparam int ST_PROD   = 75;
    localparam int ST_OUT    = 76;
    localparam int PIPE_LAT  = ST_OUT;
    // trig side chain
    localparam int HN_FIRST  = 3;
    localparam int HN_LAST   = 7;
    localparam int ST_FIN    = 8;
    localparam int ST_QUAD   = 9;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [15:0]        turn_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               axis_degenerate;
    } out_item_t;

    typedef struct packed {
        logic [2:0][31:0] vec;
        logic [2:0][31:0] mag;   // raw axis, then |axis|, then prescaled
        logic [2:0]       neg;
        logic [2:0][63:0] sq;
        logic [31:0]      mx;
        logic [63:0]      ssum;  // sum of squares, then sqrt radicand
        logic [4:0]       sh;
        logic             deg;
        logic [33:0]      rem;
        logic [31:0]      root;  // axis length after the sqrt
        logic [2:0][31:0] drem;
        logic [2:0][30:0] dlo;
        logic [2:0][30:0] quo;
        logic [2:0][31:0] u;
        logic [15:0]      ang;
        quad_t            quad;
        logic [30:0]      xs;
        logic [30:0]      xc;
        logic [30:0]      x2s;
        logic [30:0]      x2c;
        logic [30:0]      ps;
        logic [30:0]      pc;
        logic [31:0]      sn;
        logic [31:0]      cs;
        logic [32:0]      t;
        logic [2:0][32:0] tu;
        logic [2:0][31:0] su;
        logic [5:0][32:0] tp;
        logic [8:0][31:0] m;
        logic [8:0][62:0] prod;
        out_item_t        res;
    } pipe_t;

    function automatic logic [30:0] horner_coef(input logic [2:0] idx);
        logic [30:0] c;
        case (idx)
            3'd0:    c = PC9;
            3'd1:    c = PC7;
            3'd2:    c = PC5;
            3'd3:    c = PC3;
            default: c = PC1;
        endcase
        return c;
    endfunction

    // Q2.30 product, round half up
    function automatic logic signed [34:0] mul_q30(input logic signed [32:0] a,
                                                   input logic signed [31:0] b);
        logic signed [64:0] pr;
        pr = a * b;
        pr = pr + 65'sd536870912;
        return $signed(pr[64:30]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/axis_angle_rotation.sv =====
// axis_angle_rotation: Rodrigues rotation of a Q16.16 point about a free-length axis.
// 76 register stages from the input accept to m_valid and m_data;
// one item per cycle sustained while no finished item is held at the output.
// Depth is set by the 32-stage bit-per-stage sqrt and the 31-stage divider.
// Whole pipe advances together; a stalled output item freezes every stage.
// aresetn (sync, low) clears all valid bits; payload registers are not reset.
`default_nettype none
`include "axis_angle_rotation_assert.svh"

module axis_angle_rotation #(
    parameter int COORD_FRAC_BITS = axr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire axr_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output axr_pkg::out_item_t       m_data
);
    import axr_pkg::*;

    // Short axis: sum of raw squares below ceil(2^(2F) / 1e12).
    localparam logic [63:0] DEG_THR =
        64'(((65'd1 << (2 * COORD_FRAC_BITS)) + LEN_DIV - 65'd1) / LEN_DIV);

    function automatic logic [31:0] clamp_q30(input logic signed [34:0] v);
        if (v > 35'(ONE_Q30)) begin
            return 32'(ONE_Q30);
        end
        if (v < -35'(ONE_Q30)) begin
            return 32'(-ONE_Q30);
        end
        return v[31:0];
    endfunction

    // One pipe stage. k is the stage number; each stage touches only its own fields
    // and passes everything else through.
    function automatic pipe_t stage_fn(input int k, input pipe_t p, input logic [63:0] thr);
        pipe_t              o;
        logic [31:0]        mxv;
        logic [35:0]        sq_sh;
        logic [35:0]        sq_try;
        logic [32:0]        dv_sh;
        logic [61:0]        num;
        logic [61:0]        hp;
        logic [63:0]        fp;
        logic signed [31:0] s0;
        logic signed [31:0] c0;
        logic signed [34:0] me;
        logic signed [63:0] pr;
        logic signed [64:0] acc;
        logic signed [34:0] ro;
        logic [2:0][31:0]   rv;
        o  = p;
        rv = '0;

        // ---- axis length, normalization ----
        if (k == ST_ABS) begin
            for (int i = 0; i < 3; i++) begin
                o.neg[i] = p.mag[i][31];
                o.mag[i] = p.mag[i][31] ? (~p.mag[i] + 32'd1) : p.mag[i];
            end
        end
        if (k == ST_SQR) begin
            mxv = p.mag[0];
            for (int i = 0; i < 3; i++) begin
                o.sq[i] = 64'(p.mag[i]) * 64'(p.mag[i]);
                if (p.mag[i] > mxv) begin
                    mxv = p.mag[i];
                end
            end
            o.mx = mxv;
        end
        if (k == ST_SUM) begin
            o.ssum = p.sq[0] + p.sq[1] + p.sq[2];
            o.sh   = '0;
            for (int b = 0; b < 30; b++) begin
                if (p.mx[b]) begin
                    o.sh = 5'(30 - b);
                end
            end
            if (p.mx[31] | p.mx[30]) begin
                o.sh = '0;
            end
        end
        if (k == ST_SHIFT) begin
            o.deg = (p.ssum < thr);
            for (int i = 0; i < 3; i++) begin
                o.mag[i] = p.mag[i] << p.sh;
            end
        end
        if (k == ST_SQSC) begin
            for (int i = 0; i < 3; i++) begin
                o.sq[i] = 64'(p.mag[i]) * 64'(p.mag[i]);
            end
        end
        if (k == ST_SSC) begin
            o.ssum = p.sq[0] + p.sq[1] + p.sq[2];
            o.rem  = '0;
            o.root = '0;
        end
        if (k >= SQ_FIRST && k <= SQ_LAST) begin
            sq_sh  = {p.rem, p.ssum[63:62]};
            sq_try = {2'b00, p.root, 2'b01};
            if (sq_sh >= sq_try) begin
                o.rem  = 34'(sq_sh - sq_try);
                o.root = {p.root[30:0], 1'b1};
            end else begin
                o.rem  = 34'(sq_sh);
                o.root = {p.root[30:0], 1'b0};
            end
            o.ssum = {p.ssum[61:0], 2'b00};
        end
        if (k == ST_NUM) begin
            for (int i = 0; i < 3; i++) begin
                num       = {p.mag[i], 30'd0} + 62'(p.root[31:1]);
                o.drem[i] = {1'b0, num[61:31]};
                o.dlo[i]  = num[30:0];
                o.quo[i]  = '0;
            end
        end
        if (k >= DV_FIRST && k <= DV_LAST) begin
            for (int i = 0; i < 3; i++) begin
                dv_sh    = {p.drem[i], p.dlo[i][30]};
                o.dlo[i] = {p.dlo[i][29:0], 1'b0};
                if (dv_sh >= {1'b0, p.root}) begin
                    o.drem[i] = 32'(dv_sh - {1'b0, p.root});
                    o.quo[i]  = {p.quo[i][29:0], 1'b1};
                end else begin
                    o.drem[i] = dv_sh[31:0];
                    o.quo[i]  = {p.quo[i][29:0], 1'b0};
                end
            end
        end
        if (k == ST_SIGN) begin
            for (int i = 0; i < 3; i++) begin
                o.u[i] = p.neg[i] ? (32'd0 - {1'b0, p.quo[i]}) : {1'b0, p.quo[i]};
            end
        end

        // ---- trig side chain ----
        if (k == ST_ABS) begin
            o.quad = quad_t'(p.ang[15:14]);
            o.xs   = {1'b0, p.ang[13:0], 16'd0};
            o.xc   = {15'd16384 - {1'b0, p.ang[13:0]}, 16'd0};
        end
        if (k == ST_SQR) begin
            hp    = 62'(p.xs) * 62'(p.xs) + 62'(HALF_Q30);
            o.x2s = 31'(hp >> 30);
            hp    = 62'(p.xc) * 62'(p.xc) + 62'(HALF_Q30);
            o.x2c = 31'(hp >> 30);
            o.ps  = PC11;
            o.pc  = PC11;
        end
        if (k >= HN_FIRST && k <= HN_LAST) begin
            hp   = 62'(p.x2s) * 62'(p.ps) + 62'(HALF_Q30);
            o.ps = horner_coef(3'(k - HN_FIRST)) - 31'(hp >> 30);
            hp   = 62'(p.x2c) * 62'(p.pc) + 62'(HALF_Q30);
            o.pc = horner_coef(3'(k - HN_FIRST)) - 31'(hp >> 30);
        end
        if (k == ST_FIN) begin
            fp   = 64'(p.xs) * 64'(p.ps) + HALF_Q30;
            o.ps = (fp[63:30] > 34'(ONE_Q30)) ? 31'(ONE_Q30) : fp[60:30];
            fp   = 64'(p.xc) * 64'(p.pc) + HALF_Q30;
            o.pc = (fp[63:30] > 34'(ONE_Q30)) ? 31'(ONE_Q30) : fp[60:30];
        end
        if (k == ST_QUAD) begin
            s0 = $signed({1'b0, p.ps});
            c0 = $signed({1'b0, p.pc});
            unique case (p.quad)
                QUAD_I: begin
                    o.sn = s0;
                    o.cs = c0;
                end
                QUAD_II: begin
                    o.sn = c0;
                    o.cs = -s0;
                end
                QUAD_III: begin
                    o.sn = -s0;
                    o.cs = -c0;
                end
                default: begin
                    o.sn = -c0;
                    o.cs = s0;
                end
            endcase
            o.t = 33'(ONE_Q30) - 33'($signed(o.cs));
        end

        // ---- matrix and product ----
        if (k == ST_TU) begin
            for (int i = 0; i < 3; i++) begin
                o.tu[i] = 33'(mul_q30($signed(p.t), $signed(p.u[i])));
                o.su[i] = 32'(mul_q30(33'($signed(p.sn)), $signed(p.u[i])));
            end
        end
        if (k == ST_TUU) begin
            o.tp[0] = 33'(mul_q30($signed(p.tu[0]), $signed(p.u[1])));  // txy
            o.tp[1] = 33'(mul_q30($signed(p.tu[0]), $signed(p.u[2])));  // txz
            o.tp[2] = 33'(mul_q30($signed(p.tu[1]), $signed(p.u[2])));  // tyz
            o.tp[3] = 33'(mul_q30($signed(p.tu[0]), $signed(p.u[0])));
            o.tp[4] = 33'(mul_q30($signed(p.tu[1]), $signed(p.u[1])));
            o.tp[5] = 33'(mul_q30($signed(p.tu[2]), $signed(p.u[2])));
        end
        if (k == ST_MAT) begin
            me = 35'($signed(p.tp[3])) + 35'($signed(p.cs));
            o.m[0] = clamp_q30(me);
            me = 35'($signed(p.tp[0])) - 35'($signed(p.su[2]));
            o.m[1] = clamp_q30(me);
            me = 35'($signed(p.tp[1])) + 35'($signed(p.su[1]));
            o.m[2] = clamp_q30(me);
            me = 35'($signed(p.tp[0])) + 35'($signed(p.su[2]));
            o.m[3] = clamp_q30(me);
            me = 35'($signed(p.tp[4])) + 35'($signed(p.cs));
            o.m[4] = clamp_q30(me);
            me = 35'($signed(p.tp[2])) - 35'($signed(p.su[0]));
            o.m[5] = clamp_q30(me);
            me = 35'($signed(p.tp[1])) - 35'($signed(p.su[1]));
            o.m[6] = clamp_q30(me);
            me = 35'($signed(p.tp[2])) + 35'($signed(p.su[0]));
            o.m[7] = clamp_q30(me);
            me = 35'($signed(p.tp[5])) + 35'($signed(p.cs));
            o.m[8] = clamp_q30(me);
        end
        if (k == ST_PROD) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pr = $signed(p.m[i * 3 + j]) * $signed(p.vec[j]);
                    o.prod[i * 3 + j] = pr[62:0];
                end
            end
        end
        if (k == ST_OUT) begin
            for (int i = 0; i < 3; i++) begin
                acc = 65'($signed(p.prod[i * 3])) + 65'($signed(p.prod[i * 3 + 1]))
                    + 65'($signed(p.prod[i * 3 + 2])) + 65'sd536870912;
                ro  = $signed(acc[64:30]);
                if (ro > 35'sd2147483647) begin
                    rv[i] = 32'h7FFF_FFFF;
                end else if (ro < -35'sd2147483648) begin
                    rv[i] = 32'h8000_0000;
                end else begin
                    rv[i] = ro[31:0];
                end
            end
            o.res.rot_x           = p.deg ? p.vec[0] : rv[0];
            o.res.rot_y           = p.deg ? p.vec[1] : rv[1];
            o.res.rot_z           = p.deg ? p.vec[2] : rv[2];
            o.res.axis_degenerate = p.deg;
        end
        return o;
    endfunction

    logic                adv;
    logic [PIPE_LAT:1]   vld_reg;
    pipe_t               pipe_reg  [1:PIPE_LAT];
    pipe_t               stage_in  [1:PIPE_LAT];
    pipe_t               pipe_next [1:PIPE_LAT];

    // Global advance: everything moves unless the finished item is held at the output.
    assign adv     = ~vld_reg[PIPE_LAT] | m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_LAT];
    assign m_data  = pipe_reg[PIPE_LAT].res;

    // Stage 1 source: raw axis rides in the mag field until the abs stage.
    always_comb begin
        stage_in[1]       = '0;
        stage_in[1].vec   = {s_data.vec_z, s_data.vec_y, s_data.vec_x};
        stage_in[1].mag   = {s_data.axis_z, s_data.axis_y, s_data.axis_x};
        stage_in[1].ang   = s_data.turn_angle;
        for (int k = 2; k <= PIPE_LAT; k++) begin
            stage_in[k] = pipe_reg[k - 1];
        end
        for (int k = 1; k <= PIPE_LAT; k++) begin
            pipe_next[k] = stage_fn(k, stage_in[k], DEG_THR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-1:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 1; k <= PIPE_LAT; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // A held result must block intake.
    `AXR_ASSERT_SAME(a_stall_blocks, aclk, aresetn, m_valid && !m_ready, !s_ready)
    // An accepted item occupies stage 1 next cycle.
    `AXR_ASSERT_NEXT(a_item_enters, aclk, aresetn, s_valid && s_ready, vld_reg[1])
    // 1 - cos never goes negative after quadrant folding.
    `AXR_ASSERT_SAME(a_t_nonneg, aclk, aresetn, vld_reg[ST_QUAD], !pipe_reg[ST_QUAD].t[32])

endmodule

`default_nettype wire

// ===== tb/sv/axr_checker.sv =====
// axr_checker: watches both channels of axis_angle_rotation, predicts each rotated
// point in fixed point and compares it field by field. Depends on axr_pkg.
module axr_checker #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  axr_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  axr_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 point_count,
    output int                 short_axis_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import axr_pkg::*;

    localparam longint Q30 = 64'sd1073741824;
    localparam longint HQ  = 64'sd536870912;

    out_item_t rotated_q[$];

    function automatic longint rnd_q30(longint a, longint b);
        return (a * b + HQ) >>> 30;
    endfunction

    function automatic longint clip_q30(longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // quarter-wave sine, Q2.30, r in [0, 2^14]
    function automatic longint quarter_sine(longint unsigned r);
        longint unsigned x, x2, p;
        x = r << 16;
        x2 = (x * x + HQ) >> 30;
        p = 3864;
        p = 172272 - ((x2 * p + HQ) >> 30);
        p = 5026996 - ((x2 * p + HQ) >> 30);
        p = 85569306 - ((x2 * p + HQ) >> 30);
        p = 693598668 - ((x2 * p + HQ) >> 30);
        p = 1686629713 - ((x2 * p + HQ) >> 30);
        p = (x * p + HQ) >> 30;
        if (p > Q30) p = Q30;
        return p;
    endfunction

    function automatic out_item_t rotate_point(in_item_t it);
        out_item_t o;
        longint v[3], a[3], u[3], m[9];
        longint unsigned mag[3], s_raw, s_sc, mx, thr, len, w;
        longint s0, c0, sn, cs, t, tx, ty, tz, sx, sy, sz, txy, txz, tyz, acc;
        logic [13:0] r;
        quad_t q;
        v[0] = it.vec_x;  v[1] = it.vec_y;  v[2] = it.vec_z;
        a[0] = it.axis_x; a[1] = it.axis_y; a[2] = it.axis_z;
        s_raw = 0; mx = 0; s_sc = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (a[i] < 0) ? -a[i] : a[i];
            s_raw += mag[i] * mag[i];
            if (mag[i] > mx) mx = mag[i];
        end
        thr = ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;
        if (s_raw < thr) begin
            o.rot_x = it.vec_x; o.rot_y = it.vec_y; o.rot_z = it.vec_z;
            o.axis_degenerate = 1'b1;
            return o;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) s_sc += mag[i] * mag[i];
        len = int_sqrt(s_sc);
        for (int i = 0; i < 3; i++) begin
            w = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = (a[i] < 0) ? -longint'(w) : longint'(w);
        end
        q = quad_t'(it.turn_angle[15:14]);
        r = it.turn_angle[13:0];
        s0 = quarter_sine(r);
        c0 = quarter_sine(64'd16384 - r);
        case (q)
            QUAD_I:   begin sn = s0;  cs = c0;  end
            QUAD_II:  begin sn = c0;  cs = -s0; end
            QUAD_III: begin sn = -s0; cs = -c0; end
            default:  begin sn = -c0; cs = s0;  end
        endcase
        t = Q30 - cs;
        tx = rnd_q30(t, u[0]); ty = rnd_q30(t, u[1]); tz = rnd_q30(t, u[2]);
        sx = rnd_q30(sn, u[0]); sy = rnd_q30(sn, u[1]); sz = rnd_q30(sn, u[2]);
        txy = rnd_q30(tx, u[1]); txz = rnd_q30(tx, u[2]); tyz = rnd_q30(ty, u[2]);
        m[0] = rnd_q30(tx, u[0]) + cs; m[1] = txy - sz; m[2] = txz + sy;
        m[3] = txy + sz; m[4] = rnd_q30(ty, u[1]) + cs; m[5] = tyz - sx;
        m[6] = txz - sy; m[7] = tyz + sx; m[8] = rnd_q30(tz, u[2]) + cs;
        for (int i = 0; i < 3; i++) begin
            acc = HQ;
            for (int j = 0; j < 3; j++) acc += clip_q30(m[i*3+j]) * v[j];
            case (i)
                0: o.rot_x = sat32(acc >>> 30);
                1: o.rot_y = sat32(acc >>> 30);
                default: o.rot_z = sat32(acc >>> 30);
            endcase
        end
        o.axis_degenerate = 1'b0;
        return o;
    endfunction

    assign pending_count = rotated_q.size();

    initial begin
        fail_count = 0;
        point_count = 0;
        short_axis_count = 0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) rotated_q.push_back(rotate_point(s_data));
            if (m_valid && m_ready) begin
                point_count++;
                if (m_data.axis_degenerate) short_axis_count++;
                if (rotated_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected item, exp none got %h", $time, m_data);
                end else begin
                    want = rotated_q.pop_front();
                    if (m_data.rot_x !== want.rot_x) begin
                        fail_count++;
                        $display("%0t: rot_x exp %h got %h", $time, want.rot_x, m_data.rot_x);
                    end
                    if (m_data.rot_y !== want.rot_y) begin
                        fail_count++;
                        $display("%0t: rot_y exp %h got %h", $time, want.rot_y, m_data.rot_y);
                    end
                    if (m_data.rot_z !== want.rot_z) begin
                        fail_count++;
                        $display("%0t: rot_z exp %h got %h", $time, want.rot_z, m_data.rot_z);
                    end
                    if (m_data.axis_degenerate !== want.axis_degenerate) begin
                        fail_count++;
                        $display("%0t: axis_degenerate exp %b got %b", $time,
                                 want.axis_degenerate, m_data.axis_degenerate);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_axis_angle_rotation.sv =====
// tb_axis_angle_rotation: stimulus and verdict for axis_angle_rotation.
// Depends on axr_pkg, the block itself and axr_checker.
module tb_axis_angle_rotation;
    timeunit 1ns;
    timeprecision 1ps;
    import axr_pkg::*;

    localparam int LATENCY = PIPE_LAT;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    int fail_count, pending_count, point_count, short_axis_count;
    int idle_cycles = 0;
    bit long_hold = 1'b0;   // receiver held off while the sender floods
    bit sent_all = 1'b0;

    always #4 aclk = ~aclk;

    axis_angle_rotation u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    axr_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .point_count(point_count), .short_axis_count(short_axis_count)
    );

    // Random word biased toward small Q16.16 values, with full-range ones mixed in.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return $signed($urandom_range(0, 4)) - 2;   // near-zero, tiny axes
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    // Offer one item and hold it until accepted (changes on falling edge).
    task automatic send_item(input in_item_t it);
        @(negedge aclk);
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Back-to-back burst: valid stays high across items.
    task automatic send_burst(input int n);
        in_item_t it;
        for (int k = 0; k < n; k++) begin
            it.vec_x = rand_coord(); it.vec_y = rand_coord(); it.vec_z = rand_coord();
            it.axis_x = rand_coord(); it.axis_y = rand_coord(); it.axis_z = rand_coord();
            it.turn_angle = 16'($urandom());
            @(negedge aclk);
            s_data <= it;
            s_valid <= 1'b1;
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_fields(input logic [31:0] vx, vy, vz, ax, ay, az,
                               input logic [15:0] ang);
        in_item_t it;
        it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
        it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
        it.turn_angle = ang;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Receiver: random stall pattern, with one long hold-off on request.
    always @(negedge aclk) begin
        if (long_hold) m_ready <= 1'b0;
        else if (sent_all) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || long_hold) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d items pending", pending_count);
            $display("axis_angle_rotation regression: fail");
            $finish;
        end
    end

    initial begin
        int sent;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: quadrant edges, axis on each basis, extremes, short axis.
        send_fields(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 16'h4000);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'h0001_0000, 0, 0, 16'h0000);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    0, 32'h0001_0000, 0, 16'h8000);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    0, 0, 32'hFFFF_0000, 16'hC000);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hFFFF);
        send_fields(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h3FFF);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h2000);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h6000);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    0, 0, 1, 16'hA000);
        send_fields(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0, 0, 0, 16'h1111);
        send_fields(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 0, 0, 0, 16'hFFFF);
        send_fields(32'h0001_0000, 0, 0, 0, 1, 0, 16'h5555);
        send_fields(32'h0001_0000, 0, 0, 32'hFFFF_FFFF, 0, 0, 16'h4001);
        send_fields(32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 1, 0, 16'h8001);
        send_fields(32'h0003_0000, 32'h0004_0000, 0, 2, 2, 2, 16'hBFFF);

        // Pressure: sender floods while the receiver holds off.
        fork
            send_burst(120);
            begin
                @(negedge aclk);
                long_hold = 1'b1;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end
        join
        // Sender pauses until everything is back.
        wait_drained();

        sent = 135;
        while (sent < 465) begin
            int n;
            n = $urandom_range(1, 30);
            send_burst(n);
            sent += n;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12)) @(negedge aclk);
        end

        sent_all = 1'b1;
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d rotated points, %0d with a short axis,", point_count,
                 short_axis_count);
        $display("including quadrant edges, saturation, and a long output stall");
        if (fail_count == 0 && pending_count == 0)
            $display("axis_angle_rotation regression: pass");
        else
            $display("axis_angle_rotation regression: fail");
        $finish;
    end
endmodule
